@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top level of the identify response parser
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked at every rising edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication, checked at every rising edge outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ hw/rtl/idr_pkg.sv @@
// shared types and constants of the identify response parser
// no dependencies; used by idr_in_stage, idr_parse_fsm, idr_out_reg and the top level
`timescale 1ns / 1ps
`default_nettype none

package idr_pkg;

  // parse phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE     = 15'h0001,
    PH_VERSION  = 15'h0002,
    PH_REVISION = 15'h0004,
    PH_FEATURE  = 15'h0008,
    PH_A1_TYPE  = 15'h0010,
    PH_A1_ALG   = 15'h0020,
    PH_A2_TYPE  = 15'h0040,
    PH_A2_ALG   = 15'h0080,
    PH_TKT_LEN  = 15'h0100,
    PH_TICKET   = 15'h0200,
    PH_UID      = 15'h0400,
    PH_SKIP_LEN = 15'h0800,
    PH_SKIP     = 15'h1000,
    PH_DONE     = 15'h2000,
    PH_ERROR    = 15'h4000
  } phase_t;

  // parse status codes
  localparam logic [1:0] STATUS_BUSY  = 2'd0;
  localparam logic [1:0] STATUS_DONE  = 2'd1;
  localparam logic [1:0] STATUS_ERROR = 2'd2;

  // feature codes of the list
  localparam logic [7:0] FEAT_END         = 8'h00;
  localparam logic [7:0] FEAT_AUTH        = 8'h01;
  localparam logic [7:0] FEAT_AUTH_TICKET = 8'h02;
  localparam logic [7:0] FEAT_UID_SKIP    = 8'h06;
  localparam logic [7:0] FEAT_SKIP        = 8'h07;

  // algorithm id after a start (aes would be 8'hff)
  localparam logic [7:0] ALG_ID_DES = 8'h00;

  // one received byte as held in the input register
  typedef struct packed {
    logic       start_of_response;
    logic [7:0] rx_byte;
  } item_t;

  // one result transaction
  typedef struct packed {
    logic [1:0] parse_status;
    logic       ticket_byte_valid;
    logic [7:0] ticket_byte;
    logic [7:0] ticket_position;
    logic       identified_present;
    logic [7:0] reference_standard;
    logic [7:0] standard_version;
    logic [7:0] standard_revision;
    logic       can_authenticate;
    logic [7:0] algorithm_id;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/idr_in_if.sv @@
// input channel of the identify response parser: valid/ready plus one body byte
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface idr_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_response;
  logic [7:0] rx_byte;

  modport source (output valid, output start_of_response, output rx_byte, input ready);
  modport sink   (input valid, input start_of_response, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/idr_out_if.sv @@
// result channel of the identify response parser: valid/ready plus result fields
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface idr_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] parse_status;
  logic       ticket_byte_valid;
  logic [7:0] ticket_byte;
  logic [7:0] ticket_position;
  logic       identified_present;
  logic [7:0] reference_standard;
  logic [7:0] standard_version;
  logic [7:0] standard_revision;
  logic       can_authenticate;
  logic [7:0] algorithm_id;

  modport source (
    output valid, output parse_status, output ticket_byte_valid, output ticket_byte,
    output ticket_position, output identified_present, output reference_standard,
    output standard_version, output standard_revision, output can_authenticate,
    output algorithm_id, input ready
  );
  modport sink (
    input valid, input parse_status, input ticket_byte_valid, input ticket_byte,
    input ticket_position, input identified_present, input reference_standard,
    input standard_version, input standard_revision, input can_authenticate,
    input algorithm_id, output ready
  );
endinterface

`default_nettype wire

@@ hw/rtl/idr_in_stage.sv @@
// input register of the identify response parser
// depends on idr_pkg and idr_in_if
`timescale 1ns / 1ps
`default_nettype none

module idr_in_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  idr_in_if.sink              in_if,
  input  wire logic           down_ready,
  output logic                item_valid,
  output idr_pkg::item_t      item
);

  logic           valid_r;
  logic           valid_nxt;
  idr_pkg::item_t item_r;
  logic           take;
  logic           drain;

  // register frees up when its byte moves on in the same cycle
  assign drain       = valid_r && down_ready;
  assign in_if.ready = !valid_r || down_ready;
  assign take        = in_if.valid && in_if.ready;

  // occupancy
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (take) begin
      item_r.start_of_response <= in_if.start_of_response;
      item_r.rx_byte           <= in_if.rx_byte;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ hw/rtl/idr_parse_fsm.sv @@
// parse state machine: header registers, feature decoding and ticket tracking
// depends on idr_pkg
`timescale 1ns / 1ps
`default_nettype none

module idr_parse_fsm (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire idr_pkg::item_t  item,
  output idr_pkg::result_t     result
);

  idr_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] remain_r, remain_nxt;
  logic [7:0] tkt_idx_r, tkt_idx_nxt;
  logic [7:0] ref_std_r, ref_std_nxt;
  logic [7:0] version_r, version_nxt;
  logic [7:0] revision_r, revision_nxt;
  logic       auth_r, auth_nxt;
  logic [7:0] alg_r, alg_nxt;
  logic       hdr_seen_r, hdr_seen_nxt;
  logic       tvalid;
  logic [7:0] b;
  logic [7:0] remain_dec;

  assign b          = item.rx_byte;
  assign remain_dec = remain_r - 8'd1;

  // next state for the byte in the input register
  always_comb begin
    phase_nxt    = phase_r;
    remain_nxt   = remain_r;
    tkt_idx_nxt  = tkt_idx_r;
    ref_std_nxt  = ref_std_r;
    version_nxt  = version_r;
    revision_nxt = revision_r;
    auth_nxt     = auth_r;
    alg_nxt      = alg_r;
    hdr_seen_nxt = hdr_seen_r;
    tvalid       = 1'b0;
    if (item.start_of_response) begin
      auth_nxt     = 1'b0;
      alg_nxt      = idr_pkg::ALG_ID_DES;
      tkt_idx_nxt  = 8'd0;
      remain_nxt   = 8'd0;
      hdr_seen_nxt = 1'b0;
      ref_std_nxt  = b;
      phase_nxt    = idr_pkg::PH_VERSION;
    end else begin
      case (phase_r)
        idr_pkg::PH_VERSION: begin
          version_nxt = b;
          phase_nxt   = idr_pkg::PH_REVISION;
        end
        idr_pkg::PH_REVISION: begin
          revision_nxt = b;
          hdr_seen_nxt = 1'b1;
          phase_nxt    = idr_pkg::PH_FEATURE;
        end
        idr_pkg::PH_FEATURE: begin
          case (b)
            idr_pkg::FEAT_END:         phase_nxt = idr_pkg::PH_DONE;
            idr_pkg::FEAT_AUTH:        phase_nxt = idr_pkg::PH_A1_TYPE;
            idr_pkg::FEAT_AUTH_TICKET: phase_nxt = idr_pkg::PH_A2_TYPE;
            idr_pkg::FEAT_UID_SKIP:    phase_nxt = idr_pkg::PH_UID;
            idr_pkg::FEAT_SKIP:        phase_nxt = idr_pkg::PH_SKIP_LEN;
            default:                   phase_nxt = idr_pkg::PH_ERROR;
          endcase
        end
        idr_pkg::PH_A1_TYPE: begin
          auth_nxt  = b[0];
          phase_nxt = idr_pkg::PH_A1_ALG;
        end
        idr_pkg::PH_A1_ALG: begin
          alg_nxt   = b;
          phase_nxt = idr_pkg::PH_FEATURE;
        end
        idr_pkg::PH_A2_TYPE: begin
          auth_nxt  = b[0];
          phase_nxt = idr_pkg::PH_A2_ALG;
        end
        idr_pkg::PH_A2_ALG: begin
          alg_nxt   = b;
          phase_nxt = idr_pkg::PH_TKT_LEN;
        end
        idr_pkg::PH_TKT_LEN: begin
          remain_nxt  = b;
          tkt_idx_nxt = 8'd0;
          phase_nxt   = (b != 8'd0) ? idr_pkg::PH_TICKET : idr_pkg::PH_FEATURE;
        end
        idr_pkg::PH_TICKET: begin
          tvalid      = 1'b1;
          tkt_idx_nxt = tkt_idx_r + 8'd1;
          remain_nxt  = remain_dec;
          if (remain_dec == 8'd0) begin
            phase_nxt = idr_pkg::PH_FEATURE;
          end
        end
        idr_pkg::PH_UID: begin
          phase_nxt = idr_pkg::PH_SKIP_LEN;
        end
        idr_pkg::PH_SKIP_LEN: begin
          remain_nxt = b;
          phase_nxt  = (b != 8'd0) ? idr_pkg::PH_SKIP : idr_pkg::PH_FEATURE;
        end
        idr_pkg::PH_SKIP: begin
          remain_nxt = remain_dec;
          if (remain_dec == 8'd0) begin
            phase_nxt = idr_pkg::PH_FEATURE;
          end
        end
        // idle, done and error ignore the byte
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  // result fields reflect the state after this byte
  always_comb begin
    result.parse_status       = idr_pkg::STATUS_BUSY;
    if (phase_nxt == idr_pkg::PH_DONE) begin
      result.parse_status = idr_pkg::STATUS_DONE;
    end else if (phase_nxt == idr_pkg::PH_ERROR) begin
      result.parse_status = idr_pkg::STATUS_ERROR;
    end
    result.ticket_byte_valid  = tvalid;
    result.ticket_byte        = tvalid ? b : 8'd0;
    result.ticket_position    = tvalid ? tkt_idx_r : 8'd0;
    result.identified_present = hdr_seen_nxt;
    result.reference_standard = ref_std_nxt;
    result.standard_version   = version_nxt;
    result.standard_revision  = revision_nxt;
    result.can_authenticate   = auth_nxt;
    result.algorithm_id       = alg_nxt;
  end

  // state update once per consumed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= idr_pkg::PH_IDLE;
      remain_r   <= 8'd0;
      tkt_idx_r  <= 8'd0;
      ref_std_r  <= 8'd0;
      version_r  <= 8'd0;
      revision_r <= 8'd0;
      auth_r     <= 1'b0;
      alg_r      <= idr_pkg::ALG_ID_DES;
      hdr_seen_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      remain_r   <= remain_nxt;
      tkt_idx_r  <= tkt_idx_nxt;
      ref_std_r  <= ref_std_nxt;
      version_r  <= version_nxt;
      revision_r <= revision_nxt;
      auth_r     <= auth_nxt;
      alg_r      <= alg_nxt;
      hdr_seen_r <= hdr_seen_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/idr_out_reg.sv @@
// result register of the identify response parser, drives the result channel
// depends on idr_pkg and idr_out_if
`timescale 1ns / 1ps
`default_nettype none

module idr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              res_valid,
  input  wire idr_pkg::result_t  res,
  output logic                   space,
  idr_out_if.source              out_if
);

  logic             valid_r;
  logic             valid_nxt;
  idr_pkg::result_t res_r;
  logic             load;

  // room when empty or when the held transaction leaves this cycle
  assign space = !valid_r || out_if.ready;
  assign load  = res_valid && space;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_if.valid              = valid_r;
  assign out_if.parse_status       = res_r.parse_status;
  assign out_if.ticket_byte_valid  = res_r.ticket_byte_valid;
  assign out_if.ticket_byte        = res_r.ticket_byte;
  assign out_if.ticket_position    = res_r.ticket_position;
  assign out_if.identified_present = res_r.identified_present;
  assign out_if.reference_standard = res_r.reference_standard;
  assign out_if.standard_version   = res_r.standard_version;
  assign out_if.standard_revision  = res_r.standard_revision;
  assign out_if.can_authenticate   = res_r.can_authenticate;
  assign out_if.algorithm_id       = res_r.algorithm_id;

endmodule

`default_nettype wire

@@ hw/rtl/identify_response_parser_core.sv @@
// top level of the identify response parser: input register, parse fsm, result register
// depends on idr_pkg, idr_in_if, idr_out_if, idr_in_stage, idr_parse_fsm, idr_out_reg
//
//   channel  | direction | payload
//   in_if    | sink      | start_of_response, rx_byte
//   out_if   | source    | parse_status, ticket fields, header fields, auth fields
//
// one result transaction per input transaction, one byte per cycle sustained while the result channel is ready
// a byte passes the input register, then the fsm step into the result register
// the fsm update is the only loop, so a byte can follow in every cycle unless the result channel stalls
// reset clears the parse state, the header registers and both valid flags
// a stalled result stays in the result register; one more byte waits in the input register
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module identify_response_parser_core (
  input  wire logic clk,
  input  wire logic rst_n,
  idr_in_if.sink    in_if,
  idr_out_if.source out_if
);

  logic             item_valid;
  idr_pkg::item_t   item;
  logic             space;
  logic             step;
  idr_pkg::result_t res;

  // a byte is parsed when the result register can take its result
  assign step = item_valid && space;

  idr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .down_ready (space),
    .item_valid (item_valid),
    .item       (item)
  );

  idr_parse_fsm u_parse_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (res)
  );

  idr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (step),
    .res       (res),
    .space     (space),
    .out_if    (out_if)
  );

  // checks
  `ASSERT_NEXT(a_step_gives_result, clk, rst_n, step, out_if.valid)
  `ASSERT_IMPLY(a_ticket_while_busy, clk, rst_n, out_if.valid && out_if.ticket_byte_valid, out_if.parse_status == idr_pkg::STATUS_BUSY)
  `ASSERT_IMPLY(a_no_ticket_zero, clk, rst_n, out_if.valid && !out_if.ticket_byte_valid, (out_if.ticket_byte == 8'd0) && (out_if.ticket_position == 8'd0))
  `ASSERT_IMPLY(a_status_code, clk, rst_n, out_if.valid, out_if.parse_status != 2'd3)

endmodule

`default_nettype wire
